/* rtl/pidtw_pkg.sv */
// Shared widths, codes, state encoding and unit status for the PID/twiddle block.
package pidtw_pkg;

   localparam int ERR_W      = 32;
   localparam int TIME_W     = 32;
   localparam int DIST_W     = 32;
   localparam int GAIN_W     = 32;
   localparam int STEP_W     = 31;
   localparam int COST_W     = 63;
   localparam int INTEG_W    = 48;
   localparam int CSR_DATA_W = 63;
   localparam int CSR_IDX_W  = 3;
   localparam int MUL_A_W    = 48;
   localparam int MUL_B_W    = 32;
   localparam int DIV_N_W    = 49;
   localparam int DIV_D_W    = 32;

   localparam logic [STEP_W-1:0] STEP_P_RST = 31'd655;
   localparam logic [STEP_W-1:0] STEP_I_RST = 31'd66;
   localparam logic [STEP_W-1:0] STEP_D_RST = 31'd655;
   localparam logic [DIST_W-1:0] LAP_RST    = 32'd167116800;
   localparam logic [COST_W-1:0] BEST_RST   = 63'd4294967296000;

   // gain / term selector codes
   localparam logic [1:0] IDX_P = 2'd0;
   localparam logic [1:0] IDX_I = 2'd1;
   localparam logic [1:0] IDX_D = 2'd2;

   typedef enum logic [2:0] {
      CSR_GAIN_P, CSR_GAIN_I, CSR_GAIN_D,
      CSR_STEP_P, CSR_STEP_I, CSR_STEP_D,
      CSR_LAP_LEN, CSR_BEST_COST
   } csr_idx_type;

   typedef enum logic [1:0] {
      PH_PLUS, PH_MINUS, PH_SETTLE
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SLOPE_GO, ST_SLOPE_WAIT, ST_INT_GO, ST_INT_WAIT, ST_ERR_DONE,
      ST_COST_GO, ST_COST_WAIT, ST_LAP_CHECK, ST_TW_ACT, ST_STEP_GO, ST_STEP_WAIT,
      ST_TERM_GO, ST_TERM_WAIT, ST_FINISH
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

/* rtl/pidtw_req_if.sv */
// Input item channel: error sample, time step, distance step, tune flag.
interface pidtw_req_if;
   import pidtw_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [ERR_W-1:0]  error_sample;
   logic [TIME_W-1:0]        time_step;
   logic [DIST_W-1:0]        distance_step;
   logic                     tune_enable;

   modport source (output valid, error_sample, time_step, distance_step, tune_enable,
                   input ready);
   modport sink   (input valid, error_sample, time_step, distance_step, tune_enable,
                   output ready);
endinterface

/* rtl/pidtw_rsp_if.sv */
// Result item channel: drive, current gains and tuning status.
interface pidtw_rsp_if;
   import pidtw_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [ERR_W-1:0]  drive;
   logic signed [GAIN_W-1:0] gain_p_now;
   logic signed [GAIN_W-1:0] gain_i_now;
   logic signed [GAIN_W-1:0] gain_d_now;
   logic [COST_W-1:0]        last_lap_cost;
   logic [1:0]               tune_phase;
   logic [1:0]               tune_index;
   logic                     lap_running;

   modport source (output valid, drive, gain_p_now, gain_i_now, gain_d_now,
                   last_lap_cost, tune_phase, tune_index, lap_running,
                   input ready);
   modport sink   (input valid, drive, gain_p_now, gain_i_now, gain_d_now,
                   last_lap_cost, tune_phase, tune_index, lap_running,
                   output ready);
endinterface

/* rtl/pidtw_mul.sv */
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
module pidtw_mul #(
   parameter int A_W = pidtw_pkg::MUL_A_W,
   parameter int B_W = pidtw_pkg::MUL_B_W
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [A_W-1:0]          a,
   input  logic [B_W-1:0]          b,
   output pidtw_pkg::unit_stat_type stat,
   output logic [A_W+B_W-1:0]      prod
);
   import pidtw_pkg::*;

   localparam int CNT_W = $clog2(B_W);

   logic [A_W+B_W-1:0] prod_ff, prod_in;
   logic [A_W-1:0]     mcand_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff, done_ff;
   logic [A_W:0]       part;

   always_comb begin
      part    = {1'b0, prod_ff[A_W+B_W-1:B_W]} + (prod_ff[0] ? {1'b0, mcand_ff} : '0);
      prod_in = {part, prod_ff[B_W-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(B_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         prod_ff  <= {{A_W{1'b0}}, b};
         mcand_ff <= a;
      end else if (busy_ff) begin
         prod_ff <= prod_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign prod      = prod_ff;

`ifndef SYNTH
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("mul done without run");
   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> $past(start)) else $error("mul busy without start");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("mul done while busy");
`endif
endmodule

/* rtl/pidtw_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
module pidtw_div #(
   parameter int N_W = pidtw_pkg::DIV_N_W,
   parameter int D_W = pidtw_pkg::DIV_D_W
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [N_W-1:0]          dividend,
   input  logic [D_W-1:0]          divisor,
   output pidtw_pkg::unit_stat_type stat,
   output logic [N_W-1:0]          quotient
);
   import pidtw_pkg::*;

   localparam int CNT_W = $clog2(N_W);

   logic [D_W-1:0]   rem_ff, rem_in, dvs_ff;
   logic [N_W-1:0]   quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [D_W:0]     shifted;
   logic [D_W+1:0]   trial;
   logic             qbit;

   always_comb begin
      shifted = {rem_ff, quo_ff[N_W-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs_ff};
      qbit    = !trial[D_W+1];
      rem_in  = qbit ? trial[D_W-1:0] : shifted[D_W-1:0];
      quo_in  = {quo_ff[N_W-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(N_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

`ifndef SYNTH
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("div done without run");
   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> $past(start)) else $error("div busy without start");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("div done while busy");
`endif
endmodule

/* rtl/pid_controller_with_twiddle_tuning.sv */
// PID controller with twiddle gain tuning: top level, sequencer and datapath.
//
// Usage:
//  - req_if carries one item per sample: error, time step, distance step and
//    tune flag. rsp_if returns exactly one item per input item: negated PID
//    drive, current gains, last lap cost, twiddle phase/index, lap status.
//  - csr_* is a plain write port; index follows the register list. Gains,
//    steps and best cost load their live state at once. Write only when idle.
//  - One item at a time. req_if.ready is high only while the sequencer idles.
//    An item holds the block for its whole run through the shared bit-serial
//    units: each product takes 32 shift-add steps (three drive terms, plus
//    the integral update and the lap cost square), each quotient 49 steps
//    (slope, and the step grow/shrink by 10).
//  - The result sits in an output register; the next item is accepted while it
//    waits. A finished item is held in its last state until the register
//    frees, so a stalled receiver stalls the block without losing anything.
//  - Reset (synchronous, active high) restores the default gains, steps, lap
//    length and best cost, clears all accumulators and starts a lap.
module pid_controller_with_twiddle_tuning (
   input  logic                                clock,
   input  logic                                reset,
   pidtw_req_if.sink                           req_if,
   pidtw_rsp_if.source                         rsp_if,
   input  logic                                csr_we,
   input  logic [pidtw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pidtw_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import pidtw_pkg::*;

   localparam logic signed [33:0] G_MAX34   = 34'sd2147483647;
   localparam logic signed [33:0] G_MIN34   = -34'sd2147483648;
   localparam logic signed [49:0] I_MAX50   = 50'sd140737488355327;
   localparam logic signed [49:0] I_MIN50   = -50'sd140737488355328;
   localparam logic signed [44:0] D_MAX45   = 45'sd2147483647;
   localparam logic signed [44:0] D_MIN45   = -45'sd2147483648;
   localparam logic [63:0]        TERM_LIM  = 64'd1099511627776;
   localparam logic [DIV_D_W-1:0] TEN       = 32'd10;

   // sequencer
   state_type state_ff, state_in;

   // latched item
   logic signed [ERR_W-1:0] err_ff;
   logic [TIME_W-1:0]       dt_ff;
   logic [DIST_W-1:0]       dist_ff;
   logic                    tune_ff;

   // controller and tuner state
   logic signed [GAIN_W-1:0]  gain_ff [3];
   logic signed [GAIN_W-1:0]  gain_in [3];
   logic [STEP_W-1:0]         step_ff [3];
   logic [STEP_W-1:0]         step_in [3];
   logic signed [ERR_W-1:0]   prev_ff, prev_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic signed [ERR_W-1:0]   slope_ff, slope_in;
   logic [COST_W-1:0]         cost_ff, cost_in;
   logic [COST_W-1:0]         eval_ff, eval_in;
   logic [COST_W-1:0]         best_ff, best_in;
   logic [DIST_W-1:0]         dsum_ff, dsum_in;
   logic [DIST_W-1:0]         lap_len_ff, lap_len_in;
   phase_type                 phase_ff, phase_in;
   logic [1:0]                index_ff, index_in;
   logic                      running_ff, running_in;
   logic                      lap_done_ff, lap_done_in;
   logic [1:0]                step_k_ff, step_k_in;
   logic                      grow_ff, grow_in;
   logic [1:0]                term_ff, term_in;
   logic signed [43:0]        acc_ff, acc_in;

   // result register
   logic                     rsp_valid_ff;
   logic signed [ERR_W-1:0]  drive_ff;
   logic signed [GAIN_W-1:0] out_gain_ff [3];
   logic [COST_W-1:0]        out_cost_ff;
   logic [1:0]               out_phase_ff, out_index_ff;
   logic                     out_run_ff;

   // shared units
   logic                       mul_start, div_start;
   logic [MUL_A_W-1:0]         mul_a;
   logic [MUL_B_W-1:0]         mul_b;
   logic [MUL_A_W+MUL_B_W-1:0] mul_prod;
   unit_stat_type              mul_stat, div_stat;
   logic [DIV_N_W-1:0]         div_n, div_q;
   logic [DIV_D_W-1:0]         div_d;

   // shared datapath terms
   logic                    accept, out_load;
   logic [1:0]              k, gsel, ssel;
   logic signed [GAIN_W-1:0] gain_sel;
   logic [STEP_W-1:0]       step_sel;
   logic [ERR_W-1:0]        mag_err, mag_prev, mag_slope, mag_gain;
   logic [INTEG_W-1:0]      mag_integ;
   logic signed [32:0]      diff;
   logic [32:0]             mag_diff;
   logic                    tw_lt, tw_step;
   logic                    term_opnd_neg;
   logic [34:0]             step_scaled;

   assign accept   = req_if.valid && req_if.ready;
   assign out_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_if.ready);

   always_comb begin
      k        = (index_ff > IDX_D) ? IDX_P : index_ff;
      gsel     = (state_ff == ST_TERM_GO || state_ff == ST_TERM_WAIT) ? term_ff : k;
      ssel     = (state_ff == ST_TW_ACT) ? k : step_k_ff;
      gain_sel = gain_ff[gsel];
      step_sel = step_ff[ssel];
      mag_err   = err_ff[ERR_W-1]     ? (32'd0 - err_ff)   : err_ff;
      mag_prev  = prev_ff[ERR_W-1]    ? (32'd0 - prev_ff)  : prev_ff;
      mag_slope = slope_ff[ERR_W-1]   ? (32'd0 - slope_ff) : slope_ff;
      mag_gain  = gain_sel[GAIN_W-1]  ? (32'd0 - gain_sel) : gain_sel;
      mag_integ = integ_ff[INTEG_W-1] ? (48'd0 - integ_ff) : integ_ff;
      diff      = {err_ff[ERR_W-1], err_ff} - {prev_ff[ERR_W-1], prev_ff};
      mag_diff  = diff[32] ? (33'd0 - diff) : diff;
      tw_lt     = eval_ff < best_ff;
      // a step change follows a minus trial that improved, or any settle pass
      tw_step   = (phase_ff != PH_PLUS) && !(phase_ff == PH_MINUS && !tw_lt);
      // x*11 or x*9 ahead of the divide by ten
      step_scaled = grow_ff ? ({1'b0, step_sel, 3'b000} + {3'b000, step_sel, 1'b0}
                                 + {4'b0000, step_sel})
                            : ({1'b0, step_sel, 3'b000} + {4'b0000, step_sel});
      case (term_ff)
         IDX_P:   term_opnd_neg = prev_ff[ERR_W-1];
         IDX_I:   term_opnd_neg = integ_ff[INTEG_W-1];
         default: term_opnd_neg = slope_ff[ERR_W-1];
      endcase
   end

   pidtw_mul #(.A_W(MUL_A_W), .B_W(MUL_B_W)) u_mul (
      .clock (clock), .reset (reset), .start (mul_start),
      .a (mul_a), .b (mul_b), .stat (mul_stat), .prod (mul_prod)
   );

   pidtw_div #(.N_W(DIV_N_W), .D_W(DIV_D_W)) u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .dividend (div_n), .divisor (div_d), .stat (div_stat), .quotient (div_q)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (accept) begin
                           state_in = (req_if.time_step != '0) ? ST_SLOPE_GO : ST_ERR_DONE;
                        end
         ST_SLOPE_GO:   state_in = ST_SLOPE_WAIT;
         ST_SLOPE_WAIT: if (div_stat.done) state_in = ST_INT_GO;
         ST_INT_GO:     state_in = ST_INT_WAIT;
         ST_INT_WAIT:   if (mul_stat.done) state_in = ST_ERR_DONE;
         ST_ERR_DONE:   begin
                           if (!tune_ff) state_in = ST_TERM_GO;
                           else if (running_ff) state_in = ST_COST_GO;
                           else state_in = ST_TW_ACT;
                        end
         ST_COST_GO:    state_in = ST_COST_WAIT;
         ST_COST_WAIT:  if (mul_stat.done) state_in = ST_LAP_CHECK;
         ST_LAP_CHECK:  state_in = ST_TERM_GO;
         ST_TW_ACT:     state_in = tw_step ? ST_STEP_GO : ST_TERM_GO;
         ST_STEP_GO:    state_in = ST_STEP_WAIT;
         ST_STEP_WAIT:  if (div_stat.done) state_in = ST_TERM_GO;
         ST_TERM_GO:    state_in = ST_TERM_WAIT;
         ST_TERM_WAIT:  if (mul_stat.done) begin
                           state_in = (term_ff == IDX_D) ? ST_FINISH : ST_TERM_GO;
                        end
         ST_FINISH:     if (out_load) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // unit controls and operands
   always_comb begin
      req_if.ready = (state_ff == ST_IDLE);
      mul_start    = 1'b0;
      div_start    = 1'b0;
      mul_a        = {16'd0, mag_err};
      mul_b        = dt_ff;
      div_n        = {mag_diff, 16'd0};
      div_d        = dt_ff;
      unique case (state_ff)
         ST_SLOPE_GO: div_start = 1'b1;
         ST_INT_GO:   mul_start = 1'b1;
         ST_COST_GO:  begin
                         mul_start = 1'b1;
                         mul_b     = mag_err;
                      end
         ST_STEP_GO:  begin
                         div_start = 1'b1;
                         div_n     = {14'd0, step_scaled};
                         div_d     = TEN;
                      end
         ST_TERM_GO:  begin
                         mul_start = 1'b1;
                         mul_b     = mag_gain;
                         case (term_ff)
                            IDX_P:   mul_a = {16'd0, mag_prev};
                            IDX_I:   mul_a = mag_integ;
                            default: mul_a = {16'd0, mag_slope};
                         endcase
                      end
         default:     ;
      endcase
   end

   // datapath next values
   logic signed [49:0] integ_sum, inc_s;
   logic [63:0]        cost_sum64, term_mag64;
   logic [32:0]        dsum33;
   logic [40:0]        term_clip;
   logic signed [43:0] term_s;
   logic signed [33:0] g_adj;
   logic signed [44:0] drive_neg;

   always_comb begin
      gain_in     = gain_ff;
      step_in     = step_ff;
      prev_in     = prev_ff;
      integ_in    = integ_ff;
      slope_in    = slope_ff;
      cost_in     = cost_ff;
      eval_in     = eval_ff;
      best_in     = best_ff;
      dsum_in     = dsum_ff;
      lap_len_in  = lap_len_ff;
      phase_in    = phase_ff;
      index_in    = index_ff;
      running_in  = running_ff;
      lap_done_in = lap_done_ff;
      step_k_in   = step_k_ff;
      grow_in     = grow_ff;
      term_in     = term_ff;
      acc_in      = acc_ff;

      inc_s      = err_ff[ERR_W-1] ? -$signed({2'b00, mul_prod[63:16]})
                                   : $signed({2'b00, mul_prod[63:16]});
      integ_sum  = {{2{integ_ff[INTEG_W-1]}}, integ_ff} + inc_s;
      cost_sum64 = {1'b0, cost_ff} + {1'b0, mul_prod[62:0]};
      dsum33     = {1'b0, dsum_ff} + {1'b0, dist_ff};
      term_mag64 = mul_prod[79:16];
      term_clip  = (term_mag64 > TERM_LIM) ? TERM_LIM[40:0] : term_mag64[40:0];
      term_s     = (term_opnd_neg ^ gain_sel[GAIN_W-1]) ? -$signed({3'b000, term_clip})
                                                        : $signed({3'b000, term_clip});
      drive_neg  = -$signed({acc_ff[43], acc_ff});
      g_adj      = {{2{gain_sel[GAIN_W-1]}}, gain_sel};

      case (state_ff)
         ST_IDLE: begin
            acc_in  = '0;
            term_in = IDX_P;
         end
         ST_SLOPE_WAIT: if (div_stat.done) begin
            if (diff[32]) begin
               slope_in = (div_q >= 49'h0_8000_0000) ? 32'sh8000_0000
                                                     : -$signed(div_q[31:0]);
            end else begin
               slope_in = (div_q > 49'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                    : $signed(div_q[31:0]);
            end
         end
         ST_INT_WAIT: if (mul_stat.done) begin
            if (integ_sum > I_MAX50)      integ_in = I_MAX50[INTEG_W-1:0];
            else if (integ_sum < I_MIN50) integ_in = I_MIN50[INTEG_W-1:0];
            else                          integ_in = integ_sum[INTEG_W-1:0];
         end
         ST_ERR_DONE: prev_in = err_ff;
         ST_COST_WAIT: if (mul_stat.done) begin
            cost_in = cost_sum64[63] ? '1 : cost_sum64[62:0];
            dsum_in = dsum33[32] ? '1 : dsum33[31:0];
         end
         ST_LAP_CHECK: if (dsum_ff >= lap_len_ff) begin
            if (lap_done_ff) running_in = 1'b0;
            eval_in     = cost_ff;
            cost_in     = '0;
            dsum_in     = '0;
            lap_done_in = 1'b1;
         end
         ST_TW_ACT: begin
            step_k_in = k;
            grow_in   = tw_lt;
            case (phase_ff)
               PH_PLUS: begin
                  g_adj      = g_adj + $signed({3'b000, step_sel});
                  phase_in   = PH_MINUS;
                  running_in = 1'b1;
               end
               PH_MINUS: begin
                  if (tw_lt) begin
                     best_in  = eval_ff;
                     phase_in = PH_PLUS;
                     index_in = (k == IDX_D) ? IDX_P : k + 2'd1;
                  end else begin
                     g_adj      = g_adj - $signed({2'b00, step_sel, 1'b0});
                     phase_in   = PH_SETTLE;
                     running_in = 1'b1;
                  end
               end
               default: begin
                  if (tw_lt) best_in = eval_ff;
                  else g_adj = g_adj + $signed({3'b000, step_sel});
                  phase_in = PH_PLUS;
                  index_in = (k == IDX_D) ? IDX_P : k + 2'd1;
               end
            endcase
            if (g_adj > G_MAX34)      gain_in[k] = G_MAX34[31:0];
            else if (g_adj < G_MIN34) gain_in[k] = G_MIN34[31:0];
            else                      gain_in[k] = g_adj[31:0];
         end
         ST_STEP_WAIT: if (div_stat.done) begin
            if (grow_ff && (div_q[48:31] != '0)) step_in[step_k_ff] = '1;
            else                                 step_in[step_k_ff] = div_q[30:0];
         end
         ST_TERM_WAIT: if (mul_stat.done) begin
            acc_in  = acc_ff + term_s;
            term_in = term_ff + 2'd1;
         end
         default: ;
      endcase

      // the user must make configuration writes only while idle; the block does not enforce it
      if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_GAIN_P:    gain_in[IDX_P] = csr_wdata[31:0];
            CSR_GAIN_I:    gain_in[IDX_I] = csr_wdata[31:0];
            CSR_GAIN_D:    gain_in[IDX_D] = csr_wdata[31:0];
            CSR_STEP_P:    step_in[IDX_P] = csr_wdata[30:0];
            CSR_STEP_I:    step_in[IDX_I] = csr_wdata[30:0];
            CSR_STEP_D:    step_in[IDX_D] = csr_wdata[30:0];
            CSR_LAP_LEN:   lap_len_in     = csr_wdata[31:0];
            CSR_BEST_COST: best_in        = csr_wdata[62:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         gain_ff     <= '{default: '0};
         step_ff     <= '{STEP_P_RST, STEP_I_RST, STEP_D_RST};
         prev_ff     <= '0;
         integ_ff    <= '0;
         slope_ff    <= '0;
         cost_ff     <= '0;
         eval_ff     <= '0;
         best_ff     <= BEST_RST;
         dsum_ff     <= '0;
         lap_len_ff  <= LAP_RST;
         phase_ff    <= PH_PLUS;
         index_ff    <= IDX_P;
         running_ff  <= 1'b1;
         lap_done_ff <= 1'b0;
         term_ff     <= IDX_P;
      end else begin
         state_ff    <= state_in;
         gain_ff     <= gain_in;
         step_ff     <= step_in;
         prev_ff     <= prev_in;
         integ_ff    <= integ_in;
         slope_ff    <= slope_in;
         cost_ff     <= cost_in;
         eval_ff     <= eval_in;
         best_ff     <= best_in;
         dsum_ff     <= dsum_in;
         lap_len_ff  <= lap_len_in;
         phase_ff    <= phase_in;
         index_ff    <= index_in;
         running_ff  <= running_in;
         lap_done_ff <= lap_done_in;
         term_ff     <= term_in;
      end
   end

   // item latch and scratch registers
   always_ff @(posedge clock) begin
      if (accept) begin
         err_ff  <= req_if.error_sample;
         dt_ff   <= req_if.time_step;
         dist_ff <= req_if.distance_step;
         tune_ff <= req_if.tune_enable;
      end
      step_k_ff <= step_k_in;
      grow_ff   <= grow_in;
      acc_ff    <= acc_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         if (drive_neg > D_MAX45)      drive_ff <= D_MAX45[31:0];
         else if (drive_neg < D_MIN45) drive_ff <= D_MIN45[31:0];
         else                          drive_ff <= drive_neg[31:0];
         out_gain_ff  <= gain_ff;
         out_cost_ff  <= eval_ff;
         out_phase_ff <= phase_ff;
         out_index_ff <= index_ff;
         out_run_ff   <= running_ff;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.drive         = drive_ff;
   assign rsp_if.gain_p_now    = out_gain_ff[IDX_P];
   assign rsp_if.gain_i_now    = out_gain_ff[IDX_I];
   assign rsp_if.gain_d_now    = out_gain_ff[IDX_D];
   assign rsp_if.last_lap_cost = out_cost_ff;
   assign rsp_if.tune_phase    = out_phase_ff;
   assign rsp_if.tune_index    = out_index_ff;
   assign rsp_if.lap_running   = out_run_ff;

`ifndef SYNTH
   a_mul_free: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_stat.busy) else $error("multiplier restarted while busy");
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy) else $error("divider restarted while busy");
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside finish");
   a_index_range: assert property (@(posedge clock) disable iff (reset)
      index_ff == IDX_P || index_ff == IDX_I || index_ff == IDX_D)
      else $error("tune index out of range");
   a_lap_once_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(lap_done_ff)) else $error("first-lap flag cleared");
`endif
endmodule

/* verif/testbench.sv */
// Self-checking testbench for the PID controller with twiddle gain tuning.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import pidtw_pkg::*;

   localparam longint I32_LO  = -64'sd2147483648;
   localparam longint I32_HI  = 64'sd2147483647;
   localparam longint I48_LO  = -64'sd140737488355328;
   localparam longint I48_HI  = 64'sd140737488355327;
   localparam longint TERM_MX = 64'sd1099511627776;
   localparam longint unsigned U63_MX = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam longint unsigned STEP_MX = 64'h7FFF_FFFF;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int TAIL_CYCLES = 300;

   typedef struct packed {
      logic [31:0] drive;
      logic [31:0] gp, gi, gd;
      logic [62:0] lap_cost;
      logic [1:0]  phase;
      logic [1:0]  index;
      logic        running;
   } pid_out_type;

   // Scoreboard: tracks controller/tuner state and holds expected outputs.
   class pid_scoreboard;
      longint gain[3];
      longint unsigned step[3];
      longint prev_err, integ, slope;
      longint unsigned cost_sum, eval_cost, best_cost, dist_sum, lap_len;
      logic [1:0] phase, idx;
      bit running, lap_once;
      pid_out_type expected_q[$];
      int mismatches;

      function new();
         foreach (gain[k]) gain[k] = 0;
         step[0] = STEP_P_RST; step[1] = STEP_I_RST; step[2] = STEP_D_RST;
         lap_len = LAP_RST; best_cost = BEST_RST;
         prev_err = 0; integ = 0; slope = 0;
         cost_sum = 0; eval_cost = 0; dist_sum = 0;
         phase = PH_PLUS; idx = IDX_P; running = 1; lap_once = 0;
         mismatches = 0;
      endfunction

      function longint unsigned mag(longint v);
         return v < 0 ? longint'(0) - v : v;
      endfunction

      function longint clamp(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      // Q16.16 product truncated toward zero
      function longint mul_q16(longint a, longint b);
         longint unsigned ma, mb, r;
         ma = mag(a); mb = mag(b);
         r = mb * (ma >> 16) + ((mb * (ma & 64'hFFFF)) >> 16);
         return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
      endfunction

      function void load_reg(csr_idx_type r, logic [62:0] v);
         case (r)
            CSR_GAIN_P, CSR_GAIN_I, CSR_GAIN_D: begin
               gain[int'(r)] = longint'(signed'(v[31:0]));
            end
            CSR_STEP_P, CSR_STEP_I, CSR_STEP_D: begin
               step[int'(r) - 3] = v[30:0];
            end
            CSR_LAP_LEN: lap_len = v[31:0];
            CSR_BEST_COST: best_cost = v;
            default: ;
         endcase
      endfunction

      function void nudge_gain(int k, longint times);
         gain[k] = clamp(gain[k] + times * longint'(step[k]), I32_LO, I32_HI);
      endfunction

      function void grow(int k);
         longint unsigned v;
         v = step[k] * 11 / 10;
         step[k] = v > STEP_MX ? STEP_MX : v;
      endfunction

      function logic [1:0] next_idx(logic [1:0] k);
         return k == IDX_D ? IDX_P : k + 2'd1;
      endfunction

      function void twiddle(longint e, longint unsigned dist_in);
         int k;
         longint unsigned sq, ds;
         k = idx > IDX_D ? 0 : int'(idx);
         if (!running) begin
            if (phase == PH_PLUS) begin
               nudge_gain(k, 1);
               phase = PH_MINUS; running = 1;
            end else if (phase == PH_MINUS) begin
               if (eval_cost < best_cost) begin
                  best_cost = eval_cost; grow(k);
                  phase = PH_PLUS; idx = next_idx(k);
               end else begin
                  nudge_gain(k, -2);
                  phase = PH_SETTLE; running = 1;
               end
            end else begin
               if (eval_cost < best_cost) begin
                  best_cost = eval_cost; grow(k);
               end else begin
                  nudge_gain(k, 1);
                  step[k] = step[k] * 9 / 10;
               end
               phase = PH_PLUS; idx = next_idx(k);
            end
         end else begin
            sq = mag(e) * mag(e);
            cost_sum = (sq > U63_MX - cost_sum) ? U63_MX : cost_sum + sq;
            ds = dist_sum + dist_in;
            dist_sum = ds > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : ds;
            if (dist_sum >= lap_len) begin
               if (lap_once) running = 0;
               eval_cost = cost_sum;
               cost_sum = 0; dist_sum = 0; lap_once = 1;
            end
         end
      endfunction

      // Accepted input item: advance the controller and queue its output.
      function void note_input(logic [31:0] err, logic [31:0] dt, logic [31:0] dist_in,
                               bit tune);
         longint e, diff, inc, tp, ti, td, drv;
         longint unsigned q, dtl;
         pid_out_type o;
         e = longint'(signed'(err));
         dtl = dt;
         if (dtl != 0) begin
            diff = e - prev_err;
            q = (mag(diff) << 16) / dtl;
            inc = longint'((mag(e) * dtl) >> 16);
            if (diff < 0) slope = q >= 64'd2147483648 ? I32_LO : -longint'(q);
            else slope = q > 64'd2147483647 ? I32_HI : longint'(q);
            if (e < 0) inc = -inc;
            integ = clamp(integ + inc, I48_LO, I48_HI);
         end
         prev_err = e;
         if (tune) twiddle(e, dist_in);
         tp = clamp(mul_q16(prev_err, gain[0]), -TERM_MX, TERM_MX);
         ti = clamp(mul_q16(integ, gain[1]), -TERM_MX, TERM_MX);
         td = clamp(mul_q16(slope, gain[2]), -TERM_MX, TERM_MX);
         drv = clamp(-(tp + ti + td), I32_LO, I32_HI);
         o.drive = drv[31:0];
         o.gp = gain[0][31:0]; o.gi = gain[1][31:0]; o.gd = gain[2][31:0];
         o.lap_cost = eval_cost[62:0];
         o.phase = phase; o.index = idx; o.running = running;
         expected_q.push_back(o);
      endfunction

      function void check_result(pid_out_type a);
         pid_out_type x;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected output item, drive %h", a.drive);
            return;
         end
         x = expected_q.pop_front();
         if (a !== x) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch: exp drive %h gains %h %h %h cost %h ph %0d ix %0d run %0d",
                        x.drive, x.gp, x.gi, x.gd, x.lap_cost, x.phase, x.index, x.running);
               $display("          got drive %h gains %h %h %h cost %h ph %0d ix %0d run %0d",
                        a.drive, a.gp, a.gi, a.gd, a.lap_cost, a.phase, a.index, a.running);
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic clock, reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   pidtw_req_if req_bus();
   pidtw_rsp_if rsp_bus();

   pid_controller_with_twiddle_tuning uut (
      .clock(clock), .reset(reset),
      .req_if(req_bus), .rsp_if(rsp_bus),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   pid_scoreboard sb = new();
   int send_idle, recv_idle;   // idle percentages of sender and receiver
   int cycles;

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // Timeout watchdog
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   // Receiver: ready changes on the falling edge, outputs sampled on the rising edge.
   always @(negedge clock) begin
      rsp_bus.ready = ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      pid_out_type a;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         a.drive = rsp_bus.drive;
         a.gp = rsp_bus.gain_p_now; a.gi = rsp_bus.gain_i_now; a.gd = rsp_bus.gain_d_now;
         a.lap_cost = rsp_bus.last_lap_cost;
         a.phase = rsp_bus.tune_phase; a.index = rsp_bus.tune_index;
         a.running = rsp_bus.lap_running;
         sb.check_result(a);
      end
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_sample(logic [31:0] err, logic [31:0] dt, logic [31:0] dist_in,
                              bit tune);
      while ($urandom_range(99) < send_idle) begin
         req_bus.valid = 0;
         @(negedge clock);
      end
      req_bus.valid = 1;
      req_bus.error_sample = err;
      req_bus.time_step = dt;
      req_bus.distance_step = dist_in;
      req_bus.tune_enable = tune;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_input(err, dt, dist_in, tune);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_bus.valid = 0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic csr_write(csr_idx_type r, logic [62:0] v);
      csr_we = 1;
      csr_index = r;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 0;
      sb.load_reg(r, v);
   endtask

   // Register settings per phase; the extremes sit in settings 2 and 3.
   task automatic apply_setting(int s);
      case (s)
         1: begin
            csr_write(CSR_GAIN_P, 63'd65536);
            csr_write(CSR_GAIN_I, 63'd655);
            csr_write(CSR_GAIN_D, 63'd32768);
            csr_write(CSR_STEP_P, 63'd6553);
            csr_write(CSR_STEP_I, 63'd655);
            csr_write(CSR_STEP_D, 63'd6553);
            csr_write(CSR_LAP_LEN, 63'd655360);
            csr_write(CSR_BEST_COST, 63'd4294967296000);
         end
         2: begin
            csr_write(CSR_GAIN_P, 63'h0000_0000_7FFF_FFFF);
            csr_write(CSR_GAIN_I, 63'h7FFF_FFFF_8000_0000);
            csr_write(CSR_GAIN_D, 63'h0000_0000_8000_0000);
            csr_write(CSR_STEP_P, 63'h7FFF_FFFF);
            csr_write(CSR_STEP_I, 63'h7FFF_FFFF);
            csr_write(CSR_STEP_D, 63'h7FFF_FFFF);
            csr_write(CSR_LAP_LEN, 63'd0);
            csr_write(CSR_BEST_COST, 63'h7FFF_FFFF_FFFF_FFFF);
         end
         3: begin
            csr_write(CSR_GAIN_P, 63'd0);
            csr_write(CSR_GAIN_I, 63'd0);
            csr_write(CSR_GAIN_D, 63'd0);
            csr_write(CSR_STEP_P, 63'd0);
            csr_write(CSR_STEP_I, 63'd0);
            csr_write(CSR_STEP_D, 63'd0);
            csr_write(CSR_LAP_LEN, 63'hFFFF_FFFF);
            csr_write(CSR_BEST_COST, 63'd0);
         end
         4, 5: begin
            // random gains and steps, short laps
            csr_write(CSR_GAIN_P, {31'd0, $urandom()});
            csr_write(CSR_GAIN_I, 63'({$urandom(), $urandom()}));
            csr_write(CSR_GAIN_D, {31'd0, $urandom()});
            csr_write(CSR_STEP_P, 63'($urandom_range(200000)));
            csr_write(CSR_STEP_I, 63'($urandom()));
            csr_write(CSR_STEP_D, 63'($urandom_range(200000)));
            csr_write(CSR_LAP_LEN, 63'($urandom_range(32'h0100_0000)));
            csr_write(CSR_BEST_COST, 63'({$urandom(), $urandom()}));
         end
         default: begin
            // back to the power-up values
            csr_write(CSR_GAIN_P, 63'd0);
            csr_write(CSR_GAIN_I, 63'd0);
            csr_write(CSR_GAIN_D, 63'd0);
            csr_write(CSR_STEP_P, 63'(STEP_P_RST));
            csr_write(CSR_STEP_I, 63'(STEP_I_RST));
            csr_write(CSR_STEP_D, 63'(STEP_D_RST));
            csr_write(CSR_LAP_LEN, 63'(LAP_RST));
            csr_write(CSR_BEST_COST, 63'(BEST_RST));
         end
      endcase
   endtask

   function automatic logic [31:0] rand_error();
      int pick;
      pick = $urandom_range(99);
      if (pick < 8) return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      if (pick < 28) return $urandom();
      return 32'($signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
   endfunction

   function automatic logic [31:0] rand_dt();
      int pick;
      pick = $urandom_range(99);
      if (pick < 10) return 32'd0;
      if (pick < 20) return $urandom();
      if (pick < 25) return 32'd1;
      return $urandom_range(32'h0002_0000, 1);
   endfunction

   // Distance per item: a lap usually spans a handful of items.
   function automatic logic [31:0] rand_dist();
      int pick;
      longint unsigned part;
      pick = $urandom_range(99);
      if (pick < 8) return $urandom();
      if (pick < 12) return 32'hFFFF_FFFF;
      part = sb.lap_len / $urandom_range(6, 1);
      return 32'(part + $urandom_range(255));
   endfunction

   initial begin
      logic [31:0] e_ext [6];
      reset = 1;
      csr_we = 0; csr_index = '0; csr_wdata = '0;
      req_bus.valid = 0;
      req_bus.error_sample = '0; req_bus.time_step = '0;
      req_bus.distance_step = '0; req_bus.tune_enable = 0;
      rsp_bus.ready = 0;
      send_idle = 24; recv_idle = 80;
      repeat (12) @(negedge clock);
      reset = 0;
      @(negedge clock);

      // Directed: extremes of every field, zero and tiny time steps, tune off.
      send_sample(32'h7FFF_FFFF, 32'h0001_0000, 32'd0, 1'b0);
      send_sample(32'h8000_0000, 32'h0000_0001, 32'd0, 1'b0);   // slope saturates low
      send_sample(32'h7FFF_FFFF, 32'h0000_0001, 32'd0, 1'b0);   // slope saturates high
      send_sample(32'h0001_0000, 32'd0, 32'd0, 1'b0);           // zero dt holds slope
      send_sample(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      // Drive the tuner with mostly one-item laps through every phase and index.
      e_ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_8000,
                32'hFFFF_0000, 32'h0000_0000, 32'h0010_0000};
      for (int n = 0; n < 20; n++)
         send_sample(e_ext[n % 6], (n % 5 == 0) ? 32'd0 : 32'h0000_4000,
                     (n % 4 == 3) ? 32'd1 : 32'hFFFF_FFFF, 1'b1);

      // Random phases; each after the first applies its own register setting.
      for (int s = 0; s < 7; s++) begin
         if (s == 2) begin send_idle = 80; recv_idle = 24; end
         if (s == 5) begin send_idle = 0;  recv_idle = 0;  end
         if (s != 0) begin
            wait_drained();
            apply_setting(s);
         end
         for (int n = 0; n < 250; n++) begin
            if (s == 1 && n == 120) wait_drained();   // hold off until all results arrive
            send_sample(rand_error(), rand_dt(), rand_dist(),
                        $urandom_range(99) < 90);
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
